### sv/assert_macros.svh
// Assertion macros for the two-body step block, used by the sequencer tbgs_ctrl.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/tbgs_pkg.sv
// Shared constants and types for the two-body step block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tbgs_pkg;

    localparam int W          = 64;
    localparam int MU_W       = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int MUL_A_W    = 198;
    localparam int MUL_B_W    = 66;
    localparam int MUL_STEPS  = 66;
    localparam int SRC_W      = 130;
    localparam int ROOT_W     = 65;
    localparam int REM_W      = 66;
    localparam int SQ_STEPS   = 65;
    localparam int L3_W       = 195;
    localparam int NUM_W      = 207;
    localparam int DIV_STEPS  = 207;
    localparam int CNT_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MU_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MU_SECOND = 2'd1;

    // datapath operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_DIFF    = 4'd2;
    localparam logic [3:0] OP_MUL_LD  = 4'd3;
    localparam logic [3:0] OP_MUL_RUN = 4'd4;
    localparam logic [3:0] OP_STORE   = 4'd5;
    localparam logic [3:0] OP_SQ_LD   = 4'd6;
    localparam logic [3:0] OP_SQ_RUN  = 4'd7;
    localparam logic [3:0] OP_DIV_LD  = 4'd8;
    localparam logic [3:0] OP_DIV_RUN = 4'd9;
    localparam logic [3:0] OP_ACC     = 4'd10;
    localparam logic [3:0] OP_UPDATE  = 4'd11;
    localparam logic [3:0] OP_OUT     = 4'd12;

    // multiply operand pairs
    localparam logic [2:0] MSEL_DX2   = 3'd0;
    localparam logic [2:0] MSEL_DY2   = 3'd1;
    localparam logic [2:0] MSEL_L2    = 3'd2;
    localparam logic [2:0] MSEL_L3    = 3'd3;
    localparam logic [2:0] MSEL_AX0   = 3'd4;
    localparam logic [2:0] MSEL_AY0   = 3'd5;
    localparam logic [2:0] MSEL_AX1   = 3'd6;
    localparam logic [2:0] MSEL_AY1   = 3'd7;

    // product destinations
    localparam logic [2:0] STSEL_S    = 3'd0;
    localparam logic [2:0] STSEL_SADD = 3'd1;
    localparam logic [2:0] STSEL_L3   = 3'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] sel;
    } cmd_t;

endpackage

### sv/tbgs_dp.sv
// Datapath of the two-body step: body state, shared multiply, root and divide units.
// Depends on tbgs_pkg; driven by tbgs_ctrl commands.
`timescale 1ns / 1ps

module tbgs_dp
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tbgs_pkg::cmd_t                     cmd,
    input  logic                               cfg_we,
    input  logic [tbgs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tbgs_pkg::MU_W-1:0]          cfg_data,
    input  logic [4*tbgs_pkg::W-1:0]           in_data,
    input  logic [1:0]                         in_user,
    output logic [4*tbgs_pkg::W-1:0]           out_data,
    output logic [1:0]                         out_user,
    output logic                               sep_zero
);

    localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63]))
            return {1'b1, a[63] ? NEG_LIM : POS_LIM};
        return {1'b0, r};
    endfunction

    logic [tbgs_pkg::MU_W-1:0]   mu_first_reg, mu_second_reg;
    logic [63:0]                 pos_x_reg [2];
    logic [63:0]                 pos_y_reg [2];
    logic [63:0]                 vel_x_reg [2];
    logic [63:0]                 vel_y_reg [2];
    logic                        coin_reg, sat_reg;

    logic [63:0]                 mx_reg, my_reg;
    logic                        nx_reg, ny_reg;
    logic [tbgs_pkg::MUL_A_W-1:0] ma_reg, prod_reg;
    logic [tbgs_pkg::MUL_B_W-1:0] mb_reg;
    logic [tbgs_pkg::SRC_W-1:0]  s_reg, src_reg;
    logic [tbgs_pkg::REM_W-1:0]  srem_reg;
    logic [tbgs_pkg::ROOT_W-1:0] root_reg;
    logic [tbgs_pkg::L3_W-1:0]   l3_reg, drem_reg;
    logic [tbgs_pkg::NUM_W-1:0]  num_reg;
    logic [63:0]                 q_reg;
    logic                        ovf_reg;
    logic [63:0]                 acc_reg [4];
    logic [4*tbgs_pkg::W-1:0]    out_data_reg;
    logic [1:0]                  out_user_reg;

    // separation
    logic        dx_ge, dy_ge;
    logic [63:0] dxm, dym;
    always_comb
    begin
        dx_ge = ($signed(pos_x_reg[1]) >= $signed(pos_x_reg[0]));
        dy_ge = ($signed(pos_y_reg[1]) >= $signed(pos_y_reg[0]));
        dxm   = dx_ge ? pos_x_reg[1] - pos_x_reg[0] : pos_x_reg[0] - pos_x_reg[1];
        dym   = dy_ge ? pos_y_reg[1] - pos_y_reg[0] : pos_y_reg[0] - pos_y_reg[1];
    end

    // multiply operand select
    logic [tbgs_pkg::MUL_A_W-1:0] ma_sel;
    logic [tbgs_pkg::MUL_B_W-1:0] mb_sel;
    always_comb
    begin
        unique case (cmd.sel)
            tbgs_pkg::MSEL_DX2: begin ma_sel = 198'(mx_reg); mb_sel = 66'(mx_reg); end
            tbgs_pkg::MSEL_DY2: begin ma_sel = 198'(my_reg); mb_sel = 66'(my_reg); end
            tbgs_pkg::MSEL_L2:  begin ma_sel = 198'(root_reg); mb_sel = 66'(root_reg); end
            tbgs_pkg::MSEL_L3:
            begin
                ma_sel = 198'(prod_reg[tbgs_pkg::SRC_W-1:0]);
                mb_sel = 66'(root_reg);
            end
            tbgs_pkg::MSEL_AX0: begin ma_sel = 198'(mu_second_reg); mb_sel = 66'(mx_reg); end
            tbgs_pkg::MSEL_AY0: begin ma_sel = 198'(mu_second_reg); mb_sel = 66'(my_reg); end
            tbgs_pkg::MSEL_AX1: begin ma_sel = 198'(mu_first_reg); mb_sel = 66'(mx_reg); end
            default:            begin ma_sel = 198'(mu_first_reg); mb_sel = 66'(my_reg); end
        endcase
    end

    // root step
    logic [tbgs_pkg::REM_W+1:0] sq_r, sq_t, sq_d;
    logic                       sq_ge;
    always_comb
    begin
        sq_r  = {srem_reg, src_reg[tbgs_pkg::SRC_W-1 -: 2]};
        sq_t  = {1'b0, root_reg, 2'b01};
        sq_ge = (sq_r >= sq_t);
        sq_d  = sq_r - sq_t;
    end

    // divide step
    logic [tbgs_pkg::L3_W:0] dv_r, dv_d;
    logic                    dv_ge;
    always_comb
    begin
        dv_r  = {drem_reg, num_reg[tbgs_pkg::NUM_W-1]};
        dv_ge = (dv_r >= {1'b0, l3_reg});
        dv_d  = dv_r - {1'b0, l3_reg};
    end

    // acceleration clip and sign
    logic        ac_neg, ac_clip;
    logic [63:0] ac_lim, ac_mag, ac_val;
    always_comb
    begin
        case (cmd.sel[1:0])
            2'd0:    ac_neg = nx_reg;
            2'd1:    ac_neg = ny_reg;
            2'd2:    ac_neg = !nx_reg;
            default: ac_neg = !ny_reg;
        endcase
        ac_lim  = ac_neg ? NEG_LIM : POS_LIM;
        ac_clip = ovf_reg || (q_reg > ac_lim);
        ac_mag  = ac_clip ? ac_lim : q_reg;
        ac_val  = ac_neg ? 64'd0 - ac_mag : ac_mag;
    end

    // Euler update
    logic [64:0] up_px [2];
    logic [64:0] up_py [2];
    logic [64:0] up_vx [2];
    logic [64:0] up_vy [2];
    logic        up_sat;
    always_comb
    begin
        up_sat = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            up_px[i] = sat_add(pos_x_reg[i], {{16{vel_x_reg[i][63]}}, vel_x_reg[i][63:16]});
            up_py[i] = sat_add(pos_y_reg[i], {{16{vel_y_reg[i][63]}}, vel_y_reg[i][63:16]});
            up_vx[i] = sat_add(vel_x_reg[i], acc_reg[2*i]);
            up_vy[i] = sat_add(vel_y_reg[i], acc_reg[2*i+1]);
            up_sat   = up_sat | up_px[i][64] | up_py[i][64] | up_vx[i][64] | up_vy[i][64];
        end
    end

    // architectural state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_first_reg  <= '0;
            mu_second_reg <= '0;
            coin_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
                vel_x_reg[i] <= '0;
                vel_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == tbgs_pkg::REG_MU_FIRST))
                mu_first_reg <= cfg_data;
            if (cfg_we && (cfg_index == tbgs_pkg::REG_MU_SECOND))
                mu_second_reg <= cfg_data;
            unique case (cmd.op)
                tbgs_pkg::OP_LOAD:
                begin
                    pos_x_reg[in_user[1]] <= in_data[63:0];
                    pos_y_reg[in_user[1]] <= in_data[127:64];
                    vel_x_reg[in_user[1]] <= in_data[191:128];
                    vel_y_reg[in_user[1]] <= in_data[255:192];
                    coin_reg <= 1'b0;
                    sat_reg  <= 1'b0;
                end
                tbgs_pkg::OP_DIFF:
                begin
                    coin_reg <= (dxm == 64'd0) && (dym == 64'd0);
                    sat_reg  <= 1'b0;
                end
                tbgs_pkg::OP_ACC:
                    sat_reg <= sat_reg | ac_clip;
                tbgs_pkg::OP_UPDATE:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        pos_x_reg[i] <= up_px[i][63:0];
                        pos_y_reg[i] <= up_py[i][63:0];
                        vel_x_reg[i] <= up_vx[i][63:0];
                        vel_y_reg[i] <= up_vy[i][63:0];
                    end
                    sat_reg <= sat_reg | up_sat;
                end
                default: ;
            endcase
        end
    end

    // working registers of the shared arithmetic units
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tbgs_pkg::OP_DIFF:
            begin
                mx_reg <= dxm;
                my_reg <= dym;
                nx_reg <= !dx_ge;
                ny_reg <= !dy_ge;
            end
            tbgs_pkg::OP_MUL_LD:
            begin
                ma_reg   <= ma_sel;
                mb_reg   <= mb_sel;
                prod_reg <= '0;
            end
            tbgs_pkg::OP_MUL_RUN:
            begin
                if (mb_reg[0])
                    prod_reg <= prod_reg + ma_reg;
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            tbgs_pkg::OP_STORE:
            begin
                case (cmd.sel)
                    tbgs_pkg::STSEL_S:    s_reg  <= prod_reg[tbgs_pkg::SRC_W-1:0];
                    tbgs_pkg::STSEL_SADD: s_reg  <= s_reg + prod_reg[tbgs_pkg::SRC_W-1:0];
                    default:              l3_reg <= prod_reg[tbgs_pkg::L3_W-1:0];
                endcase
            end
            tbgs_pkg::OP_SQ_LD:
            begin
                src_reg  <= s_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            tbgs_pkg::OP_SQ_RUN:
            begin
                srem_reg <= sq_ge ? sq_d[tbgs_pkg::REM_W-1:0] : sq_r[tbgs_pkg::REM_W-1:0];
                root_reg <= {root_reg[tbgs_pkg::ROOT_W-2:0], sq_ge};
                src_reg  <= src_reg << 2;
            end
            tbgs_pkg::OP_DIV_LD:
            begin
                num_reg  <= {prod_reg[126:0], 80'd0};
                drem_reg <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
            end
            tbgs_pkg::OP_DIV_RUN:
            begin
                drem_reg <= dv_ge ? dv_d[tbgs_pkg::L3_W-1:0] : dv_r[tbgs_pkg::L3_W-1:0];
                num_reg  <= num_reg << 1;
                q_reg    <= {q_reg[62:0], dv_ge};
                ovf_reg  <= ovf_reg | q_reg[63];
            end
            tbgs_pkg::OP_ACC:
                acc_reg[cmd.sel[1:0]] <= ac_val;
            tbgs_pkg::OP_OUT:
            begin
                out_data_reg <= {pos_y_reg[1], pos_x_reg[1], pos_y_reg[0], pos_x_reg[0]};
                out_user_reg <= {sat_reg, coin_reg};
            end
            default: ;
        endcase
    end

    assign out_data = out_data_reg;
    assign out_user = out_user_reg;
    assign sep_zero = coin_reg;

endmodule

### sv/tbgs_ctrl.sv
// Sequencer of the two-body step: handshakes and the order of datapath operations.
// Depends on tbgs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbgs_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_mode,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic           sep_zero,
    output tbgs_pkg::cmd_t cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CHK     = 4'd1;
    localparam logic [3:0] ST_MUL_LD  = 4'd2;
    localparam logic [3:0] ST_MUL_RUN = 4'd3;
    localparam logic [3:0] ST_STORE   = 4'd4;
    localparam logic [3:0] ST_SQ_LD   = 4'd5;
    localparam logic [3:0] ST_SQ_RUN  = 4'd6;
    localparam logic [3:0] ST_DIV_LD  = 4'd7;
    localparam logic [3:0] ST_DIV_RUN = 4'd8;
    localparam logic [3:0] ST_ACC     = 4'd9;
    localparam logic [3:0] ST_UPD     = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;

    logic [3:0]                 state_reg, state_next;
    logic [tbgs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]                 midx_reg, midx_next;
    logic                       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        midx_next      = midx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = tbgs_pkg::OP_NOP;
        cmd.sel        = midx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = in_mode ? tbgs_pkg::OP_DIFF : tbgs_pkg::OP_LOAD;
                    state_next = in_mode ? ST_CHK : ST_OUT;
                end
            end
            ST_CHK:
            begin
                midx_next  = tbgs_pkg::MSEL_DX2;
                state_next = sep_zero ? ST_OUT : ST_MUL_LD;
            end
            ST_MUL_LD:
            begin
                cmd.op     = tbgs_pkg::OP_MUL_LD;
                cnt_next   = '0;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                cmd.op   = tbgs_pkg::OP_MUL_RUN;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbgs_pkg::CNT_W'(tbgs_pkg::MUL_STEPS - 1))
                begin
                    unique case (midx_reg) inside
                        tbgs_pkg::MSEL_DX2, tbgs_pkg::MSEL_DY2, tbgs_pkg::MSEL_L3:
                            state_next = ST_STORE;
                        tbgs_pkg::MSEL_L2:
                        begin
                            midx_next  = tbgs_pkg::MSEL_L3;
                            state_next = ST_MUL_LD;
                        end
                        default:
                            state_next = ST_DIV_LD;
                    endcase
                end
            end
            ST_STORE:
            begin
                cmd.op = tbgs_pkg::OP_STORE;
                unique case (midx_reg)
                    tbgs_pkg::MSEL_DX2:
                    begin
                        cmd.sel    = tbgs_pkg::STSEL_S;
                        midx_next  = tbgs_pkg::MSEL_DY2;
                        state_next = ST_MUL_LD;
                    end
                    tbgs_pkg::MSEL_DY2:
                    begin
                        cmd.sel    = tbgs_pkg::STSEL_SADD;
                        state_next = ST_SQ_LD;
                    end
                    default:
                    begin
                        cmd.sel    = tbgs_pkg::STSEL_L3;
                        midx_next  = tbgs_pkg::MSEL_AX0;
                        state_next = ST_MUL_LD;
                    end
                endcase
            end
            ST_SQ_LD:
            begin
                cmd.op     = tbgs_pkg::OP_SQ_LD;
                cnt_next   = '0;
                state_next = ST_SQ_RUN;
            end
            ST_SQ_RUN:
            begin
                cmd.op   = tbgs_pkg::OP_SQ_RUN;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbgs_pkg::CNT_W'(tbgs_pkg::SQ_STEPS - 1))
                begin
                    midx_next  = tbgs_pkg::MSEL_L2;
                    state_next = ST_MUL_LD;
                end
            end
            ST_DIV_LD:
            begin
                cmd.op     = tbgs_pkg::OP_DIV_LD;
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.op   = tbgs_pkg::OP_DIV_RUN;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tbgs_pkg::CNT_W'(tbgs_pkg::DIV_STEPS - 1))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = tbgs_pkg::OP_ACC;
                if (midx_reg == tbgs_pkg::MSEL_AY1)
                    state_next = ST_UPD;
                else
                begin
                    midx_next  = midx_reg + 1'b1;
                    state_next = ST_MUL_LD;
                end
            end
            ST_UPD:
            begin
                cmd.op     = tbgs_pkg::OP_UPDATE;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = tbgs_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            midx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            midx_reg      <= midx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, state_reg != ST_IDLE)
    `ASSERT_NEXT(a_out_loads_valid, clk, rst_n, (state_reg == ST_OUT) && (!out_valid_reg || out_ready), out_valid_reg)
    `ASSERT_SAME(a_div_count_range, clk, rst_n, state_reg == ST_DIV_RUN, cnt_reg < tbgs_pkg::CNT_W'(tbgs_pkg::DIV_STEPS))

endmodule

### sv/two_body_gravity_step.sv
// Two-body gravity stepper, forward Euler with a one second time step. A load item (tuser
// mode bit 0) writes one body's position (Q47.16) and velocity (Q31.32) and returns the
// four positions. A step item finds the separation, its squared length, the integer root
// L and L^3, then four accelerations mu*|d|*2^80 / L^3, and moves the positions with the
// old velocities before adding the accelerations; clipping anywhere raises the saturated
// flag and zero separation holds the state and raises coincident. All wide arithmetic
// runs on one shared shift-add multiplier, one bit-serial root and one restoring divider,
// and the four divisions take most of a step. The result sits in an output register, so
// the next item is taken while the last result waits.
// Depends on tbgs_pkg, tbgs_ctrl and tbgs_dp.
`timescale 1ns / 1ps

module two_body_gravity_step
(
    input  logic                           clk,
    input  logic                           rst_n,
    // item input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [255:0]                   s_axis_tdata,  // load_pos_x, load_pos_y, load_vel_x, load_vel_y
    input  logic [1:0]                     s_axis_tuser,  // mode, body
    // result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [255:0]                   m_axis_tdata,  // first_x, first_y, second_x, second_y
    output logic [1:0]                     m_axis_tuser,  // coincident, saturated
    // configuration writes
    input  logic                           cfg_we,
    input  logic [tbgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbgs_pkg::MU_W-1:0]      cfg_data
);

    tbgs_pkg::cmd_t cmd;
    logic           sep_zero;

    // Sequence the datapath; it issues one operation per cycle, a no-op while idle or waiting on the result side.
    tbgs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_mode   (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sep_zero  (sep_zero),
        .cmd       (cmd)
    );

    // Hold body state, mu registers and the shared arithmetic units.
    tbgs_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .sep_zero  (sep_zero)
    );

endmodule

### bench/two_body_gravity_step_check.sv
// Checker for the two-body step block: watches the item, result and register ports,
// predicts each result in fixed point and compares it field by field.
// Depends on tbgs_pkg for the register indexes and widths.
`timescale 1ns / 1ps

module two_body_gravity_step_check
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [255:0]                   s_axis_tdata,
    input  logic [1:0]                     s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [255:0]                   m_axis_tdata,
    input  logic [1:0]                     m_axis_tuser,
    input  logic                           cfg_we,
    input  logic [tbgs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbgs_pkg::MU_W-1:0]      cfg_data,
    output int                             fail_count,
    output int                             pending
);

    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] first_x;
        logic [63:0] first_y;
        logic [63:0] second_x;
        logic [63:0] second_y;
        logic        coincident;
        logic        saturated;
    } bodies_t;

    logic [tbgs_pkg::MU_W-1:0] grav_first, grav_second;
    logic [63:0]     pos_x [2];
    logic [63:0]     pos_y [2];
    logic [63:0]     vel_x [2];
    logic [63:0]     vel_y [2];
    bodies_t         positions_due [$];

    // Clip a signed sum at the 64-bit range.
    function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b, inout bit sat);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
        begin
            sat = 1'b1;
            r = a[63] ? NEG_LIMIT : POS_LIMIT;
        end
        return r;
    endfunction

    // mu * |d| * 2^80 / L^3, clipped to the signed range of its direction.
    function automatic logic [63:0] pull(logic [tbgs_pkg::MU_W-1:0] mu, logic [63:0] mag,
                                         bit neg, logic [255:0] cube, inout bit sat);
        logic [255:0] num, q;
        logic [63:0]  lim, v;
        num = 256'(mu) * 256'(mag);
        num = num << 80;
        q = num / cube;
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        if (q > 256'(lim))
        begin
            v = lim;
            sat = 1'b1;
        end
        else
            v = q[63:0];
        return neg ? -v : v;
    endfunction

    // Apply one item to the shadow state and return the positions after it.
    function automatic bodies_t advance_bodies(logic [255:0] data, logic [1:0] user);
        bodies_t      res;
        bit           sat, nx, ny;
        logic [63:0]  mx, my;
        logic [63:0]  ax [2];
        logic [63:0]  ay [2];
        logic [255:0] s, root, cand, cube;
        sat = 1'b0;
        res.coincident = 1'b0;
        if (user[0] == 1'b0)
        begin
            pos_x[user[1]] = data[63:0];
            pos_y[user[1]] = data[127:64];
            vel_x[user[1]] = data[191:128];
            vel_y[user[1]] = data[255:192];
        end
        else
        begin
            nx = $signed(pos_x[1]) < $signed(pos_x[0]);
            ny = $signed(pos_y[1]) < $signed(pos_y[0]);
            mx = nx ? pos_x[0] - pos_x[1] : pos_x[1] - pos_x[0];
            my = ny ? pos_y[0] - pos_y[1] : pos_y[1] - pos_y[0];
            if (mx == 0 && my == 0)
                res.coincident = 1'b1;
            else
            begin
                s = 256'(mx) * 256'(mx) + 256'(my) * 256'(my);
                root = '0;
                for (int b = 65; b >= 0; b--)
                begin
                    cand = root | (256'd1 << b);
                    if (cand * cand <= s)
                        root = cand;
                end
                cube = root * root * root;
                ax[0] = pull(grav_second, mx, nx, cube, sat);
                ay[0] = pull(grav_second, my, ny, cube, sat);
                ax[1] = pull(grav_first, mx, !nx, cube, sat);
                ay[1] = pull(grav_first, my, !ny, cube, sat);
                for (int i = 0; i < 2; i++)
                begin
                    pos_x[i] = clip_add(pos_x[i], 64'($signed(vel_x[i]) >>> 16), sat);
                    pos_y[i] = clip_add(pos_y[i], 64'($signed(vel_y[i]) >>> 16), sat);
                    vel_x[i] = clip_add(vel_x[i], ax[i], sat);
                    vel_y[i] = clip_add(vel_y[i], ay[i], sat);
                end
            end
        end
        res.first_x = pos_x[0];
        res.first_y = pos_y[0];
        res.second_x = pos_x[1];
        res.second_y = pos_y[1];
        res.saturated = sat;
        return res;
    endfunction

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        fail_count++;
        $display("%0t mismatch %s expected %h actual %h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bodies_t want;
        if (!rst_n)
        begin
            grav_first = '0;
            grav_second = '0;
            for (int i = 0; i < 2; i++)
            begin
                pos_x[i] = '0;
                pos_y[i] = '0;
                vel_x[i] = '0;
                vel_y[i] = '0;
            end
            positions_due.delete();
        end
        else
        begin
            // check results before taking a new item at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (positions_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected result expected none actual %h", $time,
                             m_axis_tdata);
                end
                else
                begin
                    want = positions_due.pop_front();
                    if (m_axis_tdata[63:0] !== want.first_x)
                        report("first_x", want.first_x, m_axis_tdata[63:0]);
                    if (m_axis_tdata[127:64] !== want.first_y)
                        report("first_y", want.first_y, m_axis_tdata[127:64]);
                    if (m_axis_tdata[191:128] !== want.second_x)
                        report("second_x", want.second_x, m_axis_tdata[191:128]);
                    if (m_axis_tdata[255:192] !== want.second_y)
                        report("second_y", want.second_y, m_axis_tdata[255:192]);
                    if (m_axis_tuser[0] !== want.coincident)
                        report("coincident", 64'(want.coincident), 64'(m_axis_tuser[0]));
                    if (m_axis_tuser[1] !== want.saturated)
                        report("saturated", 64'(want.saturated), 64'(m_axis_tuser[1]));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == tbgs_pkg::REG_MU_FIRST)
                    grav_first = cfg_data;
                else if (cfg_index == tbgs_pkg::REG_MU_SECOND)
                    grav_second = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                positions_due.push_back(advance_bodies(s_axis_tdata, s_axis_tuser));
        end
        pending = positions_due.size();
    end

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

endmodule

### bench/two_body_gravity_step_test.sv
// Top of the two-body step bench: drives load and step items with random gaps,
// stalls the result side, changes the gravity registers between phases, gives the verdict.
// Depends on tbgs_pkg, two_body_gravity_step and two_body_gravity_step_check.
`timescale 1ns / 1ps

module two_body_gravity_step_test;

    localparam logic [63:0] TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BOTTOM = 64'h8000_0000_0000_0000;
    localparam logic       MODE_LOAD = 1'b0;
    localparam logic       MODE_STEP = 1'b1;
    localparam int         RANDOM_ITEMS = 1100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [255:0]         s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [255:0]         m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 cfg_we = 1'b0;
    logic [tbgs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tbgs_pkg::MU_W-1:0]      cfg_data = '0;
    int                   fail_count;
    int                   pending;
    int                   sent;
    int                   ready_hold = 0;

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    two_body_gravity_step dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    two_body_gravity_step_check check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one; half the items go back to back.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    // Positions: mostly near the origin so the physics stays in range, some at the edges.
    function automatic logic [63:0] pick_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 64'($signed(rand64() << 24) >>> 24);
        if (r < 8)
            return rand64();
        if (r == 8)
            return $urandom_range(0, 1) ? TOP : BOTTOM;
        return TOP - 64'($urandom_range(0, 65535) << 16);
    endfunction

    // Velocities: mostly modest, some full range and extremes.
    function automatic logic [63:0] pick_vel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 64'($signed(rand64() << 16) >>> 16);
        if (r < 9)
            return rand64();
        return $urandom_range(0, 1) ? TOP : BOTTOM;
    endfunction

    // Result side: ready in runs, short stalls, and a rare long one.
    always @(posedge clk)
    begin
        int r;
        if (ready_hold == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(1, 20);
            end
            else if (r < 95)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(1, 4);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(20, 150);
            end
        end
        else
            ready_hold--;
    end

    // Present one item after a random gap and hold it until accepted. tvalid stays
    // high across back-to-back items, so only the data changes at that edge.
    task automatic send(logic mode, logic body, logic [63:0] px, logic [63:0] py,
                        logic [63:0] vx, logic [63:0] vy);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {vy, vx, py, px};
        s_axis_tuser <= {body, mode};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sent++;
    endtask

    task automatic step_bodies();
        send(MODE_STEP, 1'($urandom_range(0, 1)), rand64(), rand64(), rand64(), rand64());
    endtask

    // Drain: drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Write both gravity registers while the block is idle.
    task automatic set_gravity(logic [tbgs_pkg::MU_W-1:0] mu_one,
                               logic [tbgs_pkg::MU_W-1:0] mu_two);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= tbgs_pkg::REG_MU_FIRST;
        cfg_data <= mu_one;
        @(posedge clk);
        cfg_index <= tbgs_pkg::REG_MU_SECOND;
        cfg_data <= mu_two;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [tbgs_pkg::MU_W-1:0] mu_pick [4];
        int              steps;
        sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Steps straight out of reset see both bodies at the origin: coincident.
        step_bodies();
        set_gravity({tbgs_pkg::MU_W{1'b1}}, 63'd6_082_000_000);
        // Unused indexes must leave the registers alone.
        cfg_we <= 1'b1;
        cfg_index <= 2'd2;
        cfg_data <= '0;
        @(posedge clk);
        cfg_index <= 2'd3;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);

        // One metre apart with the heaviest mu: acceleration clips in both directions.
        send(MODE_LOAD, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
        send(MODE_LOAD, 1'b1, 64'd1 << 16, 64'd0, 64'd0, 64'd0);
        step_bodies();
        step_bodies();
        // Bodies at opposite ends moving outward: position and velocity sums clip.
        send(MODE_LOAD, 1'b0, TOP, TOP, TOP, TOP);
        send(MODE_LOAD, 1'b1, BOTTOM, BOTTOM, BOTTOM, BOTTOM);
        step_bodies();
        send(MODE_LOAD, 1'b0, BOTTOM, TOP, BOTTOM, TOP);
        send(MODE_LOAD, 1'b1, TOP, BOTTOM, TOP, BOTTOM);
        step_bodies();
        // Tiny negative velocity rounds toward minus infinity.
        send(MODE_LOAD, 1'b0, '1, '1, '1, '1);
        send(MODE_LOAD, 1'b1, 64'd0, 64'd0, 64'd1, 64'd1);
        step_bodies();
        // Same nonzero place: coincident, state held.
        send(MODE_LOAD, 1'b0, 64'd123 << 16, -(64'd456 << 16), 64'd5, 64'd7);
        send(MODE_LOAD, 1'b1, 64'd123 << 16, -(64'd456 << 16), 64'd9, 64'd3);
        step_bodies();
        // A roughly orbital pair.
        send(MODE_LOAD, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
        send(MODE_LOAD, 1'b1, 64'd7_000_000 << 16, 64'd0, 64'd0, 64'd7_500 << 32);
        step_bodies();
        step_bodies();

        // Random phases, each under its own gravity setting, extremes included.
        mu_pick[0] = '0;
        mu_pick[1] = {tbgs_pkg::MU_W{1'b1}};
        mu_pick[2] = 63'd6_082_000_000;
        mu_pick[3] = 63'({$urandom, $urandom});
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                set_gravity(mu_pick[3], 63'({$urandom_range(0, 255), $urandom}));
            else
                set_gravity(mu_pick[phase], mu_pick[(phase + 2) % 4]);
            while (sent < (phase + 1) * (RANDOM_ITEMS / 4) + 20)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // Load both bodies, then advance a few times.
                    if ($urandom_range(0, 1))
                    begin
                        send(MODE_LOAD, 1'b0, pick_pos(), pick_pos(), pick_vel(), pick_vel());
                        send(MODE_LOAD, 1'b1, pick_pos(), pick_pos(), pick_vel(), pick_vel());
                    end
                    else
                    begin
                        send(MODE_LOAD, 1'b1, pick_pos(), pick_pos(), pick_vel(), pick_vel());
                        send(MODE_LOAD, 1'b0, pick_pos(), pick_pos(), pick_vel(), pick_vel());
                    end
                    steps = $urandom_range(1, 3);
                    repeat (steps) step_bodies();
                end
                else
                    send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand64(),
                         rand64(), rand64(), rand64());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Generous bound on the whole run.
    initial
    begin
        #40ms;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/tbgs_pkg.sv
sv/tbgs_dp.sv
sv/tbgs_ctrl.sv
sv/two_body_gravity_step.sv
bench/two_body_gravity_step_check.sv
bench/two_body_gravity_step_test.sv
